### rtl/iqf_pkg.sv
package iqf_pkg;

	localparam int DEPTH_DEF       = 4096;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int OP_W            = 3;
	localparam int DROP_W          = 64;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_PUSH    = 3'd0;
	localparam op_t OP_POP     = 3'd1;
	localparam op_t OP_DISCARD = 3'd2;
	localparam op_t OP_SUB     = 3'd3;
	localparam op_t OP_KEEP    = 3'd4;
	localparam op_t OP_CLEAR   = 3'd5;

endpackage

### rtl/iqf_ram.sv
module iqf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/iq_sample_fifo_drop_oldest.sv
// Queue of complex I/Q samples that keeps the newest ones: a push into a full queue drops the
// front sample and bumps the 64-bit dropped count. Samples live in one RAM with a registered
// read port; head and occupancy are registers. One operation is accepted per cycle while
// in_stall is low; its result beat passes through the internal result stage and then the output
// register. Subtract is a read-modify-write of one RAM entry and holds off the input while its
// writeback goes through the single write port. A stalled output holds the input once the
// internal result stage is also full. No clearing pass is needed after reset. The user writes
// capacity through the cfg port only while the queue is idle; the block does not enforce this.
// Values above DEPTH act as DEPTH; at capacity zero a push only bumps the dropped count.
module iq_sample_fifo_drop_oldest #(
	parameter int DEPTH       = iqf_pkg::DEPTH_DEF,
	parameter int SAMPLE_BITS = iqf_pkg::SAMPLE_BITS_DEF,
	localparam int IDX_W      = $clog2(DEPTH),
	localparam int CNT_W      = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CNT_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  iqf_pkg::op_t                  op,
	input  logic signed [SAMPLE_BITS-1:0] sample_i,
	input  logic signed [SAMPLE_BITS-1:0] sample_q,
	input  logic [IDX_W-1:0]              offset,
	input  logic [CNT_W-1:0]              amount,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_i,
	output logic signed [SAMPLE_BITS-1:0] out_q,
	output logic                          status,
	output logic [CNT_W-1:0]              fill_level,
	output logic [iqf_pkg::DROP_W-1:0]    dropped_total
);

	localparam int SUM_W  = CNT_W + 1;
	localparam int DATA_W = 2 * SAMPLE_BITS;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

	function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] x);
		logic [SUM_W-1:0] r;
		r = (x >= DEPTH_S) ? (x - DEPTH_S) : x;
		return r[IDX_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sub(
		input logic signed [SAMPLE_BITS-1:0] a,
		input logic signed [SAMPLE_BITS-1:0] b
	);
		logic [SAMPLE_BITS:0] d;
		d = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
		if (d[SAMPLE_BITS] != d[SAMPLE_BITS-1]) begin
			return d[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
			                      : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		return d[SAMPLE_BITS-1:0];
	endfunction

	logic [CNT_W-1:0]           cap_q;
	logic [IDX_W-1:0]           head_q, head_d;
	logic [CNT_W-1:0]           occ_q, occ_d;
	logic [iqf_pkg::DROP_W-1:0] drop_q, drop_d;

	logic                       vld_s1, pop_s1, sub_s1, status_s1;
	logic [CNT_W-1:0]           fill_s1;
	logic [iqf_pkg::DROP_W-1:0] drop_s1;
	logic [IDX_W-1:0]           addr_s1;
	logic signed [SAMPLE_BITS-1:0] est_i_s1, est_q_s1;

	logic                       out_valid_q, status_q;
	logic signed [SAMPLE_BITS-1:0] out_i_q, out_q_q;
	logic [CNT_W-1:0]           fill_q;
	logic [iqf_pkg::DROP_W-1:0] dropped_q;

	logic [CNT_W-1:0]           cap_eff;
	logic [SUM_W-1:0]           head_x;
	logic                       in_acc, s1_adv;
	logic                       status_d, push_wr, pop_ok, sub_ok;
	logic [IDX_W-1:0]           raddr;
	logic                       ram_we, ram_re;
	logic [IDX_W-1:0]           ram_waddr;
	logic [DATA_W-1:0]          ram_wdata, ram_rdata;
	logic signed [SAMPLE_BITS-1:0] rd_i, rd_q;

	assign cfg_ready = 1'b1;
	assign cap_eff   = (cap_q > DEPTH_C) ? DEPTH_C : cap_q;
	assign head_x    = SUM_W'(head_q);

	assign s1_adv   = vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall = vld_s1 && (sub_s1 || !s1_adv);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		head_d   = head_q;
		occ_d    = occ_q;
		drop_d   = drop_q;
		status_d = 1'b0;
		push_wr  = 1'b0;
		pop_ok   = 1'b0;
		sub_ok   = 1'b0;
		raddr    = head_q;
		unique case (op)
			iqf_pkg::OP_PUSH: begin
				if (cap_eff == '0) begin
					drop_d = drop_q + 1'b1;
				end else begin
					push_wr = 1'b1;
					if (occ_q >= cap_eff) begin
						head_d = wrap(head_x + SUM_W'(1));
						drop_d = drop_q + 1'b1;
					end else begin
						occ_d = occ_q + 1'b1;
					end
				end
			end
			iqf_pkg::OP_POP: begin
				if (occ_q == '0) begin
					status_d = 1'b1;
				end else begin
					pop_ok = 1'b1;
					head_d = wrap(head_x + SUM_W'(1));
					occ_d  = occ_q - 1'b1;
				end
			end
			iqf_pkg::OP_DISCARD: begin
				if (amount > occ_q) begin
					status_d = 1'b1;
				end else begin
					head_d = wrap(head_x + SUM_W'(amount));
					occ_d  = occ_q - amount;
				end
			end
			iqf_pkg::OP_SUB: begin
				if (CNT_W'(offset) >= occ_q) begin
					status_d = 1'b1;
				end else begin
					sub_ok = 1'b1;
					raddr  = wrap(head_x + SUM_W'(offset));
				end
			end
			iqf_pkg::OP_KEEP: begin
				if (amount > occ_q) begin
					status_d = 1'b1;
				end else begin
					occ_d = amount;
				end
			end
			iqf_pkg::OP_CLEAR: begin
				occ_d  = '0;
				head_d = '0;
			end
			default: begin
				status_d = 1'b1;
			end
		endcase
	end

	assign rd_i = ram_rdata[DATA_W-1:SAMPLE_BITS];
	assign rd_q = ram_rdata[SAMPLE_BITS-1:0];

	assign ram_re    = in_acc && (pop_ok || sub_ok);
	assign ram_we    = (in_acc && push_wr) || (vld_s1 && sub_s1);
	assign ram_waddr = (vld_s1 && sub_s1) ? addr_s1 : wrap(head_x + SUM_W'(occ_q));
	assign ram_wdata = (vld_s1 && sub_s1) ? {sat_sub(rd_i, est_i_s1), sat_sub(rd_q, est_q_s1)}
	                                      : {sample_i, sample_q};

	iqf_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CNT_W'(DEPTH);
			head_q <= '0;
			occ_q  <= '0;
			drop_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (in_acc) begin
				head_q <= head_d;
				occ_q  <= occ_d;
				drop_q <= drop_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			pop_s1 <= 1'b0;
			sub_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
			pop_s1 <= pop_ok;
			sub_s1 <= sub_ok;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
			pop_s1 <= 1'b0;
			sub_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_s1 <= status_d;
			fill_s1   <= occ_d;
			drop_s1   <= drop_d;
			addr_s1   <= raddr;
			est_i_s1  <= sample_i;
			est_q_s1  <= sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_i_q   <= pop_s1 ? rd_i : '0;
			out_q_q   <= pop_s1 ? rd_q : '0;
			status_q  <= status_s1;
			fill_q    <= fill_s1;
			dropped_q <= drop_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_i         = out_i_q;
	assign out_q         = out_q_q;
	assign status        = status_q;
	assign fill_level    = fill_q;
	assign dropped_total = dropped_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= DEPTH_C)
		else $error("occupancy above depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(head_q) < DEPTH_S)
		else $error("head index out of range");

	a_drop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && op != iqf_pkg::OP_PUSH |=> drop_q == $past(drop_q))
		else $error("dropped count moved on a non-push beat");

	a_sub_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && sub_s1 |-> !in_acc && !ram_re)
		else $error("beat accepted during subtract writeback");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(vld_s1))
		else $error("output beat without a result stage entry");

endmodule
